// ----- hdl/pmac_pkg.sv -----
// ----------------------------------------------------------------------------
// pmac_pkg
// Shared types and constants of the paged MMU access checker.
// ----------------------------------------------------------------------------
package pmac_pkg;

    localparam int PAGE_ENTRIES = 256;
    localparam int PHYS_BYTES   = 65536;
    localparam int TBL_AW       = $clog2(PAGE_ENTRIES);
    localparam int MEM_AW       = $clog2(PHYS_BYTES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;

    localparam logic [3:0] SHIFT_MIN   = 4'd4;
    localparam logic [3:0] SHIFT_MAX   = 4'd12;
    localparam logic [3:0] SHIFT_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_ENABLED = 1'd0,
        CFG_PAGE_SHIFT    = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_XLATE = 3'd0,
        MODE_FETCH = 3'd1,
        MODE_LOAD  = 3'd2,
        MODE_STORE = 3'd3,
        MODE_ENTRY = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PAGE_FAULT = 3'd1,
        ST_SEGV       = 3'd2,
        ST_ACCESS     = 3'd3,
        ST_NO_TABLE   = 3'd4
    } t_status;

    // access kind, same encoding as the low bits of the mode
    typedef enum logic [1:0] {
        ACC_XLATE = 2'd0,
        ACC_FETCH = 2'd1,
        ACC_LOAD  = 2'd2,
        ACC_STORE = 2'd3
    } t_acc;

    typedef enum logic [1:0] {
        OP_DONE   = 2'd0,   // result known at classify time
        OP_ENTRY  = 2'd1,   // table entry write
        OP_ACCESS = 2'd2    // lookup and memory access
    } t_op;

    typedef enum logic [1:0] {
        B_IDLE   = 2'd0,
        B_LOOKUP = 2'd1,
        B_LOAD   = 2'd2
    } t_bstate;

    typedef struct packed {
        logic        table_en;
        logic [3:0]  page_shift;
    } t_cfg;

    // bit layout: 17 modified, 16 referenced, 15 present, 14 x, 13 w, 12 r, 11:0 frame
    typedef struct packed {
        logic        modified;
        logic        referenced;
        logic        present;
        logic        x;
        logic        w;
        logic        r;
        logic [11:0] frame;
    } t_entry;

    typedef struct packed {
        t_op               op;
        t_acc              acc;
        t_status           status;
        logic [TBL_AW-1:0] idx;
        logic [15:0]       offset;
        logic [3:0]        shift;
        logic [7:0]        data;
        t_entry            entry;
    } t_job;

    typedef struct packed {
        t_status     status;
        logic [15:0] paddr;
        logic [7:0]  data_out;
        logic        referenced_out;
        logic        modified_out;
    } t_rsp;

endpackage

// ----- hdl/pmac_in_if.sv -----
// ----------------------------------------------------------------------------
// pmac_in_if
// Request channel: valid/ready handshake with the access fields.
// ----------------------------------------------------------------------------
interface pmac_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] vaddr;
    logic [7:0]  data_in;
    logic [7:0]  entry_index;
    logic        perm_read;
    logic        perm_write;
    logic        perm_exec;
    logic        present_in;
    logic [11:0] frame_in;
    logic        referenced_in;
    logic        modified_in;

    modport source (
        output valid, mode, vaddr, data_in, entry_index, perm_read, perm_write,
               perm_exec, present_in, frame_in, referenced_in, modified_in,
        input  ready
    );
    modport sink (
        input  valid, mode, vaddr, data_in, entry_index, perm_read, perm_write,
               perm_exec, present_in, frame_in, referenced_in, modified_in,
        output ready
    );
endinterface

// ----- hdl/pmac_out_if.sv -----
// ----------------------------------------------------------------------------
// pmac_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface pmac_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] paddr;
    logic [7:0]  data_out;
    logic        referenced_out;
    logic        modified_out;

    modport source (
        output valid, status, paddr, data_out, referenced_out, modified_out,
        input  ready
    );
    modport sink (
        input  valid, status, paddr, data_out, referenced_out, modified_out,
        output ready
    );
endinterface

// ----- hdl/pmac_front.sv -----
// ----------------------------------------------------------------------------
// pmac_front
// Accepts requests, splits the address and sorts each item into a job.
// ----------------------------------------------------------------------------
module pmac_front (
    pmac_in_if.sink          req,
    input  pmac_pkg::t_cfg   i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output pmac_pkg::t_job   o_job
);
    import pmac_pkg::*;

    logic [3:0]  sh;
    logic [15:0] pidx;

    assign req.ready = !i_q_full;
    assign o_push    = req.valid && !i_q_full;

    always_comb begin
        if (i_cfg.page_shift < SHIFT_MIN) begin
            sh = SHIFT_MIN;
        end else if (i_cfg.page_shift > SHIFT_MAX) begin
            sh = SHIFT_MAX;
        end else begin
            sh = i_cfg.page_shift;
        end
        pidx = req.vaddr >> sh;

        o_job                  = '0;
        o_job.offset           = req.vaddr & ~(16'hFFFF << sh);
        o_job.shift            = sh;
        o_job.data             = req.data_in;
        o_job.entry.frame      = req.frame_in;
        o_job.entry.r          = req.perm_read;
        o_job.entry.w          = req.perm_write;
        o_job.entry.x          = req.perm_exec;
        o_job.entry.present    = req.present_in;
        o_job.entry.referenced = req.referenced_in;
        o_job.entry.modified   = req.modified_in;
        o_job.op               = OP_DONE;
        o_job.status           = ST_OK;
        o_job.acc              = t_acc'(req.mode[1:0]);

        case (req.mode)
            MODE_ENTRY: begin
                if (32'(req.entry_index) >= PAGE_ENTRIES) begin
                    o_job.status = ST_SEGV;
                end else begin
                    o_job.op  = OP_ENTRY;
                    o_job.idx = TBL_AW'(req.entry_index);
                end
            end
            MODE_XLATE, MODE_FETCH, MODE_LOAD, MODE_STORE: begin
                if (!i_cfg.table_en) begin
                    o_job.status = ST_NO_TABLE;
                end else if (32'(pidx) >= PAGE_ENTRIES) begin
                    o_job.status = ST_SEGV;
                end else begin
                    o_job.op  = OP_ACCESS;
                    o_job.idx = TBL_AW'(pidx);
                end
            end
            default: begin
                o_job.status = ST_ACCESS;
            end
        endcase
    end

endmodule

// ----- hdl/pmac_queue.sv -----
// ----------------------------------------------------------------------------
// pmac_queue
// Short job FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module pmac_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmac_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output pmac_pkg::t_job   o_job
);
    import pmac_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/pmac_back.sv -----
// ----------------------------------------------------------------------------
// pmac_back
// Executes jobs: page table lookup, permission checks, memory access,
// table update and the registered result.
// ----------------------------------------------------------------------------
module pmac_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  pmac_pkg::t_job   i_job,
    output logic             o_pop,
    pmac_out_if.source       rsp
);
    import pmac_pkg::*;

    // page table: RAM plus a valid bit per entry (unwritten reads as zero)
    logic [$bits(t_entry)-1:0] r_tbl_mem [PAGE_ENTRIES];
    logic [PAGE_ENTRIES-1:0]   r_tbl_vld;
    t_entry                    r_tbl_rd;
    logic                      r_tbl_rd_vld;
    // physical memory, no reset
    logic [7:0]                r_pmem [PHYS_BYTES];
    logic [7:0]                r_mem_rd;

    t_bstate r_state, n_state;
    t_job    r_cur, n_cur;
    t_rsp    r_pend, n_pend;
    t_rsp    r_rsp, n_rsp;
    logic    r_rsp_vld, n_rsp_vld;

    logic              tbl_we, tbl_re;
    logic [TBL_AW-1:0] tbl_wa, tbl_ra;
    t_entry            tbl_wd;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_a;
    logic              out_free;
    t_entry            ent, ent_new;
    logic              need_ok;
    logic [15:0]       phys;

    assign out_free           = !r_rsp_vld || rsp.ready;
    assign rsp.valid          = r_rsp_vld;
    assign rsp.status         = r_rsp.status;
    assign rsp.paddr          = r_rsp.paddr;
    assign rsp.data_out       = r_rsp.data_out;
    assign rsp.referenced_out = r_rsp.referenced_out;
    assign rsp.modified_out   = r_rsp.modified_out;

    always_comb begin
        ent  = r_tbl_rd_vld ? r_tbl_rd : '0;
        phys = (16'(ent.frame) << r_cur.shift) + r_cur.offset;
        case (r_cur.acc)
            ACC_FETCH: need_ok = ent.x;
            ACC_LOAD:  need_ok = ent.r;
            ACC_STORE: need_ok = ent.w;
            default:   need_ok = 1'b1;
        endcase
        ent_new = ent;
        if (r_cur.acc != ACC_XLATE) begin
            ent_new.referenced = 1'b1;
        end
        if (r_cur.acc == ACC_STORE) begin
            ent_new.modified = 1'b1;
        end
        mem_a = MEM_AW'(phys);
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_pend    = r_pend;
        n_rsp     = r_rsp;
        n_rsp_vld = r_rsp_vld && !rsp.ready;
        o_pop     = 1'b0;
        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_wa    = r_cur.idx;
        tbl_ra    = i_job.idx;
        tbl_wd    = ent_new;
        mem_we    = 1'b0;
        mem_re    = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    n_cur = i_job;
                    case (i_job.op)
                        OP_ACCESS: begin
                            tbl_re  = 1'b1;
                            n_state = B_LOOKUP;
                        end
                        OP_ENTRY: begin
                            tbl_we               = 1'b1;
                            tbl_wa               = i_job.idx;
                            tbl_wd               = i_job.entry;
                            n_rsp                = '0;
                            n_rsp.status         = ST_OK;
                            n_rsp.referenced_out = i_job.entry.referenced;
                            n_rsp.modified_out   = i_job.entry.modified;
                            n_rsp_vld            = 1'b1;
                        end
                        default: begin
                            n_rsp        = '0;
                            n_rsp.status = i_job.status;
                            n_rsp_vld    = 1'b1;
                        end
                    endcase
                end
            end
            B_LOOKUP: begin
                // output register is free: it was free when this job was popped
                n_rsp                = '0;
                n_rsp.referenced_out = ent.referenced;
                n_rsp.modified_out   = ent.modified;
                if (!(ent.r || ent.w || ent.x)) begin
                    n_rsp.status = ST_SEGV;
                end else if (!need_ok) begin
                    n_rsp.status = ST_ACCESS;
                end else if (!ent.present) begin
                    n_rsp.status = ST_PAGE_FAULT;
                end else begin
                    n_rsp.status         = ST_OK;
                    n_rsp.paddr          = phys;
                    n_rsp.referenced_out = ent_new.referenced;
                    n_rsp.modified_out   = ent_new.modified;
                    tbl_we               = 1'b1;
                    mem_we               = (r_cur.acc == ACC_STORE);
                    mem_re               = (r_cur.acc == ACC_FETCH) || (r_cur.acc == ACC_LOAD);
                end
                if (mem_re) begin
                    n_pend  = n_rsp;
                    n_rsp   = r_rsp;
                    n_state = B_LOAD;
                end else begin
                    n_rsp_vld = 1'b1;
                    n_state   = B_IDLE;
                end
            end
            B_LOAD: begin
                n_rsp          = r_pend;
                n_rsp.data_out = r_mem_rd;
                n_rsp_vld      = 1'b1;
                n_state        = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (tbl_re) begin
            r_tbl_rd     <= r_tbl_mem[tbl_ra];
            r_tbl_rd_vld <= r_tbl_vld[tbl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pmem[mem_a] <= r_cur.data;
        end
        if (mem_re) begin
            r_mem_rd <= r_pmem[mem_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (tbl_we) begin
            r_tbl_vld[tbl_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_pend <= n_pend;
        r_rsp  <= n_rsp;
    end

endmodule

// ----- hdl/paged_mmu_access_checker.sv -----
// ----------------------------------------------------------------------------
// paged_mmu_access_checker
// Single-level page table MMU with permission checks and a byte memory.
// ----------------------------------------------------------------------------
// Each request item is one access: translate (mode 0), fetch (1), load (2),
// store (3) or page table entry write (4). The front classifies an item in
// the cycle it is accepted (page index/offset split, table-enable and
// out-of-table checks, illegal modes) and drops a job into a two-entry
// queue. The back pops one job at a time. Items answered at classify time
// (no table, index beyond table, unknown mode) and entry writes go straight
// to the result register; translate and store go through a table RAM read,
// then check and update; fetch and load add the registered memory read
// port after that. The back takes no new job before the current one is
// answered. A result sits in an output register, so the front keeps
// accepting while a result waits, until the queue is full. Checks are
// in order: no r/w/x bit -> segmentation fault, missing permission ->
// access violation, clear present bit -> page fault. Page table entries
// read as zero until written (one valid bit per entry, cleared by
// reset); memory bytes are undefined until stored. Config writes (index
// 0 table_enabled, index 1 page_shift, clamped to 4..12) are taken any
// cycle and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module paged_mmu_access_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pmac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pmac_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    pmac_in_if.sink                            i_req,
    pmac_out_if.source                         o_rsp
);
    import pmac_pkg::*;

    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_empty;
    t_job front_job, q_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_en   <= 1'b0;
            r_cfg.page_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TABLE_ENABLED: r_cfg.table_en   <= i_cfg_wdata[0];
                CFG_PAGE_SHIFT:    r_cfg.page_shift <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    pmac_front u_front (
        .req      (i_req),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    // decoupling queue
    pmac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    // back: table lookup, memory access, result register
    pmac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (q_job),
        .o_pop     (q_pop),
        .rsp       (o_rsp)
    );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the paged MMU access checker. A local model of the
// page table and byte memory predicts each result; random gaps on both sides,
// a long output hold-off and several register settings exercise the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmac_pkg::*;

    // modes past the entry write are undefined and must be rejected
    localparam logic [2:0] MODE_BAD_LO = 3'd5;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 40;

    // one access item, fields as on the request channel
    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] vaddr;
        logic [7:0]  data_in;
        logic [7:0]  entry_index;
        logic        perm_read;
        logic        perm_write;
        logic        perm_exec;
        logic        present;
        logic [11:0] frame;
        logic        referenced;
        logic        modified;
    } t_acc_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pmac_in_if  req_if ();
    pmac_out_if rsp_if ();

    paged_mmu_access_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // ------------------------------------------------------------------
    // Model state: page table, byte memory with a written flag per byte,
    // and a copy of the two registers.
    // ------------------------------------------------------------------
    t_entry      page_tbl    [PAGE_ENTRIES];
    logic [7:0]  phys_mem    [PHYS_BYTES];
    bit          mem_written [PHYS_BYTES];
    logic        tbl_en;
    logic [3:0]  tbl_shift;

    t_rsp        expected_rsp [$];
    int          mismatches;
    int          results_seen;
    int          cycle_count;
    bit          quiet;      // no gaps on either side while set
    bit          hold_req;   // asks the result side for one long hold-off

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    // register value clamped to the legal page sizes
    function automatic int unsigned eff_shift();
        if (tbl_shift < SHIFT_MIN) return SHIFT_MIN;
        if (tbl_shift > SHIFT_MAX) return SHIFT_MAX;
        return tbl_shift;
    endfunction

    // Lookup without side effects: status, physical address and the page
    // index touched (-1 when no entry is looked at). Entry writes not handled.
    function automatic void page_walk(input t_acc_item it, output t_status st,
                                      output logic [15:0] pa, output int pidx);
        int unsigned sh;
        int unsigned page;
        int unsigned off;
        t_entry      e;
        st   = ST_OK;
        pa   = '0;
        pidx = -1;
        sh   = eff_shift();
        if (it.mode > MODE_ENTRY) begin
            st = ST_ACCESS;
        end else if (!tbl_en) begin
            st = ST_NO_TABLE;
        end else begin
            page = it.vaddr >> sh;
            off  = it.vaddr & ((1 << sh) - 1);
            if (page >= PAGE_ENTRIES) begin
                st = ST_SEGV;
            end else begin
                pidx = page;
                e    = page_tbl[page];
                // order matters: no permission at all, then the one needed,
                // then presence
                if (!(e.r || e.w || e.x))
                    st = ST_SEGV;
                else if ((it.mode == MODE_FETCH && !e.x) ||
                         (it.mode == MODE_LOAD  && !e.r) ||
                         (it.mode == MODE_STORE && !e.w))
                    st = ST_ACCESS;
                else if (!e.present)
                    st = ST_PAGE_FAULT;
                else
                    pa = 16'((32'(e.frame) << sh) + off);
            end
        end
    endfunction

    // Applies one accepted item to the model and returns its result.
    function automatic t_rsp mmu_predict(input t_acc_item it);
        t_rsp        r;
        t_status     st;
        logic [15:0] pa;
        int          pidx;
        t_entry      e;
        r = '0;
        if (it.mode == MODE_ENTRY) begin
            e = {it.modified, it.referenced, it.present, it.perm_exec,
                 it.perm_write, it.perm_read, it.frame};
            page_tbl[it.entry_index] = e;
            r.referenced_out = e.referenced;
            r.modified_out   = e.modified;
            return r;
        end
        page_walk(it, st, pa, pidx);
        r.status = st;
        if (pidx >= 0) begin
            e = page_tbl[pidx];
            if (st == ST_OK) begin
                r.paddr = pa;
                case (it.mode)
                    MODE_FETCH, MODE_LOAD: begin
                        r.data_out   = phys_mem[pa];
                        e.referenced = 1'b1;
                    end
                    MODE_STORE: begin
                        phys_mem[pa]    = it.data_in;
                        mem_written[pa] = 1'b1;
                        e.referenced    = 1'b1;
                        e.modified      = 1'b1;
                    end
                    default: ;
                endcase
                page_tbl[pidx] = e;
            end
            r.referenced_out = e.referenced;
            r.modified_out   = e.modified;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders; fields the mode ignores get random junk
    // ------------------------------------------------------------------
    function automatic t_acc_item access_item(input logic [2:0] mode,
                                              input logic [15:0] va,
                                              input logic [7:0] din);
        t_acc_item it;
        it.mode        = mode;
        it.vaddr       = va;
        it.data_in     = din;
        it.entry_index = 8'($urandom);
        {it.perm_read, it.perm_write, it.perm_exec, it.present,
         it.referenced, it.modified} = 6'($urandom);
        it.frame       = 12'($urandom);
        return it;
    endfunction

    // xwr: bit 2 execute, bit 1 write, bit 0 read
    function automatic t_acc_item entry_item(input logic [7:0] idx, input logic [2:0] xwr,
                                             input logic present, input logic [11:0] frame,
                                             input logic refd, input logic modd);
        t_acc_item it;
        it.mode        = MODE_ENTRY;
        it.vaddr       = 16'($urandom);
        it.data_in     = 8'($urandom);
        it.entry_index = idx;
        it.perm_read   = xwr[0];
        it.perm_write  = xwr[1];
        it.perm_exec   = xwr[2];
        it.present     = present;
        it.frame       = frame;
        it.referenced  = refd;
        it.modified    = modd;
        return it;
    endfunction

    // Mostly accesses aimed at a few hot pages with a few frames and offsets
    // near page edges, so stores and loads meet; the rest is entry writes,
    // unknown modes and addresses anywhere.
    function automatic t_acc_item rand_item();
        int unsigned sh;
        int unsigned pick;
        int unsigned max_page;
        int unsigned page;
        int unsigned off;
        int unsigned page_bytes;
        logic [2:0]  mode;
        sh   = eff_shift();
        pick = $urandom_range(0, 99);
        mode = 3'($urandom_range(MODE_XLATE, MODE_STORE));
        if (pick < 18)
            return entry_item(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                          : 8'($urandom),
                              {$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                               $urandom_range(0, 3) != 0},
                              $urandom_range(0, 7) != 0,
                              ($urandom_range(0, 4) != 0) ? 12'($urandom_range(0, 7))
                                                          : 12'($urandom),
                              1'($urandom), 1'($urandom));
        if (pick < 21)
            return access_item(3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI)),
                               16'($urandom), 8'($urandom));
        if (pick < 29)
            return access_item(mode, 16'($urandom), 8'($urandom));
        max_page = (1 << (16 - sh)) - 1;
        if (max_page > PAGE_ENTRIES - 1)
            max_page = PAGE_ENTRIES - 1;
        page = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                           : $urandom_range(0, max_page);
        page_bytes = 1 << sh;
        case ($urandom_range(0, 2))
            0:       off = $urandom_range(0, 3);
            1:       off = page_bytes - 1 - $urandom_range(0, 3);
            default: off = $urandom_range(0, page_bytes - 1);
        endcase
        return access_item(mode, 16'((page << sh) | off), 8'($urandom));
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Sends one item after a random gap; the prediction is taken when the
    // handshake completes, so the model is always in acceptance order.
    task automatic send_item(input t_acc_item it);
        int          gap;
        t_status     st;
        logic [15:0] pa;
        int          pidx;
        gap = gap_len();
        // a fetch or load must never hit a byte nobody stored yet: turn it
        // into a store to the same address instead
        page_walk(it, st, pa, pidx);
        if ((it.mode == MODE_FETCH || it.mode == MODE_LOAD) && st == ST_OK &&
            !mem_written[pa])
            it.mode = MODE_STORE;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.mode          <= it.mode;
        req_if.vaddr         <= it.vaddr;
        req_if.data_in       <= it.data_in;
        req_if.entry_index   <= it.entry_index;
        req_if.perm_read     <= it.perm_read;
        req_if.perm_write    <= it.perm_write;
        req_if.perm_exec     <= it.perm_exec;
        req_if.present_in    <= it.present;
        req_if.frame_in      <= it.frame;
        req_if.referenced_in <= it.referenced;
        req_if.modified_in   <= it.modified;
        req_if.valid         <= 1'b1;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        expected_rsp.push_back(mmu_predict(it));
    endtask

    // drop valid and wait until every outstanding result is back
    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_rsp.size() != 0) @(negedge i_clk);
    endtask

    // register write, only ever done with the block idle
    task automatic set_reg(input t_cfg_idx idx, input logic [3:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_TABLE_ENABLED)
            tbl_en = val[0];
        else
            tbl_shift = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial begin : rsp_sink
        int stall;
        rsp_if.ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                rsp_if.ready <= 1'b1;
            end else if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                stall--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // every accepted result against the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none pending",
                                          results_seen));
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, rsp_if.status, want.status));
                if (rsp_if.paddr !== want.paddr)
                    report_mismatch($sformatf("result %0d paddr %h, want %h",
                                              results_seen, rsp_if.paddr,
                                              want.paddr));
                if (rsp_if.data_out !== want.data_out)
                    report_mismatch($sformatf("result %0d data_out %h, want %h",
                                              results_seen, rsp_if.data_out,
                                              want.data_out));
                if (rsp_if.referenced_out !== want.referenced_out)
                    report_mismatch($sformatf("result %0d referenced %b, want %b",
                                              results_seen, rsp_if.referenced_out,
                                              want.referenced_out));
                if (rsp_if.modified_out !== want.modified_out)
                    report_mismatch($sformatf("result %0d modified %b, want %b",
                                              results_seen, rsp_if.modified_out,
                                              want.modified_out));
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Out of reset the table is off: every access reports no table, the
    // entry write still lands, undefined modes are rejected.
    task automatic test_table_disabled();
        send_item(access_item(MODE_XLATE, 16'h0000, 8'h00));
        send_item(access_item(MODE_FETCH, 16'hFFFF, 8'hFF));
        send_item(access_item(MODE_LOAD,  16'h8001, 8'h00));
        send_item(access_item(MODE_STORE, 16'h1234, 8'hA5));
        // full permissions on entry 0, used later with the largest page
        send_item(entry_item(8'd0, 3'b111, 1'b1, 12'hFFF, 1'b0, 1'b0));
        send_item(access_item(MODE_BAD_LO, 16'h0100, 8'h00));
        send_item(access_item(MODE_BAD_HI, 16'h0100, 8'h00));
    endtask

    // fault ordering, address wrap, index beyond table, shift clamping
    task automatic test_access_checks();
        set_reg(CFG_TABLE_ENABLED, 4'd1);
        // no r/w/x at all: segfault even though present
        send_item(entry_item(8'd1, 3'b000, 1'b1, 12'h005, 1'b0, 1'b0));
        send_item(access_item(MODE_XLATE, 16'h0110, 8'h00));
        // read only and absent: fetch lacks x, load and translate fault
        send_item(entry_item(8'd2, 3'b001, 1'b0, 12'h000, 1'b0, 1'b0));
        send_item(access_item(MODE_FETCH, 16'h0200, 8'h00));
        send_item(access_item(MODE_LOAD,  16'h02FF, 8'h00));
        send_item(access_item(MODE_XLATE, 16'h0280, 8'h00));
        // top frame, last offset: lands on the top byte
        send_item(entry_item(8'd3, 3'b111, 1'b1, 12'hFFF, 1'b1, 1'b1));
        send_item(access_item(MODE_STORE, 16'h03FF, 8'hFF));
        send_item(access_item(MODE_LOAD,  16'h03FF, 8'h00));
        send_item(access_item(MODE_FETCH, 16'h03FF, 8'h00));
        // last entry, write only
        send_item(entry_item(8'd255, 3'b010, 1'b1, 12'h000, 1'b0, 1'b0));
        send_item(access_item(MODE_STORE, 16'hFF00, 8'h00));
        send_item(access_item(MODE_LOAD,  16'hFF00, 8'h00));
        send_item(access_item(MODE_XLATE, 16'hFFFF, 8'h00));
        // shift below range acts as 4: page index 4095 is past the table
        set_reg(CFG_PAGE_SHIFT, 4'd0);
        send_item(access_item(MODE_LOAD, 16'hFFFF, 8'h00));
        // shift above range acts as 12: frame 0xFFF wraps the address
        set_reg(CFG_PAGE_SHIFT, 4'd15);
        send_item(access_item(MODE_STORE, 16'h0123, 8'h5A));
        send_item(access_item(MODE_LOAD,  16'h0123, 8'h00));
        set_reg(CFG_PAGE_SHIFT, SHIFT_RESET);
    endtask

    // results held off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        hold_req = 1'b1;
        repeat (24) send_item(rand_item());
    endtask

    task automatic run_phase(input logic en, input logic [3:0] sh, input int n,
                             input bit no_gaps);
        set_reg(CFG_TABLE_ENABLED, {3'b000, en});
        set_reg(CFG_PAGE_SHIFT, sh);
        quiet = no_gaps;
        repeat (n) send_item(rand_item());
        quiet = 1'b0;
    endtask

    // random traffic across page sizes, table off, and back-to-back items
    task automatic test_random_sweep();
        run_phase(1'b1, 4'd8,  150, 1'b0);
        run_phase(1'b1, 4'd4,  120, 1'b0);
        run_phase(1'b1, 4'd12, 120, 1'b0);
        run_phase(1'b0, 4'd8,  40,  1'b0);
        run_phase(1'b1, 4'd0,  60,  1'b0);
        run_phase(1'b1, 4'd15, 60,  1'b0);
        run_phase(1'b1, 4'd6,  100, 1'b1);
        repeat (6) run_phase(1'b1, 4'($urandom_range(SHIFT_MIN, SHIFT_MAX)), 35, 1'b0);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_TABLE_ENABLED;
        i_cfg_wdata          = '0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_XLATE;
        req_if.vaddr         = '0;
        req_if.data_in       = '0;
        req_if.entry_index   = '0;
        req_if.perm_read     = 1'b0;
        req_if.perm_write    = 1'b0;
        req_if.perm_exec     = 1'b0;
        req_if.present_in    = 1'b0;
        req_if.frame_in      = '0;
        req_if.referenced_in = 1'b0;
        req_if.modified_in   = 1'b0;
        foreach (page_tbl[i]) page_tbl[i] = '0;
        tbl_en       = 1'b0;
        tbl_shift    = SHIFT_RESET;
        mismatches   = 0;
        results_seen = 0;
        cycle_count  = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_disabled();
        test_access_checks();
        test_back_pressure();
        test_random_sweep();

        // all results in, then a drain wait to catch strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pmac_pkg.sv
hdl/pmac_in_if.sv
hdl/pmac_out_if.sv
hdl/pmac_front.sv
hdl/pmac_queue.sv
hdl/pmac_back.sv
hdl/paged_mmu_access_checker.sv
bench/tb.sv
